// File: hdl/inr_pkg.sv
// shared constants and types for the integer nth root core
// no dependencies; imported by inr_pow_unit, integer_nth_root_core and tb
`default_nettype none

package inr_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned PROD_BITS  = 2 * VALUE_BITS;
  localparam int unsigned DEG_BITS   = 6;

  // handshake from the power unit back to the sequencer
  typedef struct packed {
    logic done;
    logic pass;
    logic eq;
  } pow_status_t;

endpackage

`default_nettype wire

// File: hdl/inr_pow_unit.sv
// saturating power unit: base^deg compared against a cap, one multiply per cycle
// depends on inr_pkg
`default_nettype none

module inr_pow_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [inr_pkg::VALUE_BITS-1:0]     base_i,
  input  wire logic [inr_pkg::DEG_BITS-1:0]       deg_i,
  input  wire logic [inr_pkg::VALUE_BITS-1:0]     cap_i,
  output inr_pkg::pow_status_t                    status_o
);
  import inr_pkg::*;

  logic                  busy_q, busy_d;
  logic [PROD_BITS-1:0]  acc_q, acc_d;
  logic [DEG_BITS-1:0]   cnt_q, cnt_d;
  logic [PROD_BITS-1:0]  cap_ext;
  logic [PROD_BITS-1:0]  prod;
  logic                  over;
  logic                  last;

  assign cap_ext = {{(PROD_BITS-VALUE_BITS){1'b0}}, cap_i};
  // acc stays below 2^VALUE_BITS whenever it is multiplied again
  assign prod    = PROD_BITS'(acc_q[VALUE_BITS-1:0]) * PROD_BITS'(base_i);
  assign over    = acc_q > cap_ext;
  assign last    = cnt_q == deg_i;

  always_comb begin
    status_o.done = busy_q && (over || last);
    status_o.pass = !over;
    status_o.eq   = acc_q == cap_ext;
  end

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = PROD_BITS'(1);
      cnt_d  = '0;
    end else if (busy_q) begin
      if (over || last) begin
        busy_d = 1'b0;
      end else begin
        acc_d = prod;
        cnt_d = cnt_q + DEG_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0 && acc_q == PROD_BITS'(1))
    else $error("power unit did not initialize on start");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && !over && !last |=> cnt_q == $past(cnt_q) + DEG_BITS'(1))
    else $error("power unit skipped a multiply step");

  a_done_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done && !start_i |=> !busy_q)
    else $error("power unit stayed busy after done");

endmodule

`default_nettype wire

// File: hdl/integer_nth_root_core.sv
// integer nth root, floor form: bit-by-bit root search sharing one power unit
// each of the 31 root bits is rejected at once when the candidate exceeds the value, or else
// tried on the power unit, which multiplies up to degree times and stops early on overshoot.
// busy_o stays high until the result strobe, one item at a time.
// valid_o is a one-cycle strobe; the receiver cannot stall.
// reset (rst_ni low, asynchronous) returns the sequencer to idle; no result is pending.
`default_nettype none

module integer_nth_root_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [inr_pkg::VALUE_BITS-1:0]   value_i,
  input  wire logic [inr_pkg::DEG_BITS-1:0]     degree_i,
  output logic                                  valid_o,
  output logic [inr_pkg::VALUE_BITS-1:0]        root_o,
  output logic                                  exact_o
);
  import inr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRY  = 4'b0010,
    ST_POW  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [DEG_BITS-1:0]    deg_q, deg_d;
  logic [VALUE_BITS-1:0]  r_q, r_d;
  logic [VALUE_BITS-1:0]  mask_q, mask_d;
  logic [VALUE_BITS-1:0]  cand_q, cand_d;
  logic                   exact_q, exact_d;
  logic [VALUE_BITS-1:0]  cand;
  logic                   pow_start;
  pow_status_t            pow_status;

  assign cand = r_q | mask_q;

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    deg_d     = deg_q;
    r_d       = r_q;
    mask_d    = mask_q;
    cand_d    = cand_q;
    exact_d   = exact_q;
    pow_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d   = value_i;
          // degree zero behaves as degree one
          deg_d   = (degree_i == '0) ? DEG_BITS'(1) : degree_i;
          r_d     = '0;
          mask_d  = {1'b1, {(VALUE_BITS-1){1'b0}}};
          exact_d = value_i == '0;
          state_d = ST_TRY;
        end
      end
      ST_TRY: begin
        if (cand > val_q) begin
          mask_d  = mask_q >> 1;
          state_d = mask_q[0] ? ST_OUT : ST_TRY;
        end else begin
          cand_d    = cand;
          pow_start = 1'b1;
          state_d   = ST_POW;
        end
      end
      ST_POW: begin
        if (pow_status.done) begin
          if (pow_status.pass) begin
            r_d     = cand_q;
            exact_d = pow_status.eq;
          end
          mask_d  = mask_q >> 1;
          state_d = mask_q[0] ? ST_OUT : ST_TRY;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    deg_q   <= deg_d;
    r_q     <= r_d;
    mask_q  <= mask_d;
    cand_q  <= cand_d;
    exact_q <= exact_d;
  end

  inr_pow_unit u_pow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pow_start),
    .base_i   (cand_q),
    .deg_i    (deg_q),
    .cap_i    (val_q),
    .status_o (pow_status)
  );

  assign busy_o  = state_q != ST_IDLE;
  assign valid_o = state_q == ST_OUT;
  assign root_o  = r_q;
  assign exact_o = exact_q;

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o)
    else $error("core still busy after the result transfer");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POW || state_q == ST_OUT |-> r_q <= val_q)
    else $error("partial root exceeds the value");

  a_pow_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pow_start |=> state_q == ST_POW && !pow_status.done || pow_status.done)
    else $error("power trial started outside the trial sequence");

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for integer_nth_root_core: floor nth root and exactness flag
// depends on inr_pkg for the field widths; runs a directed table, then random phases
// with sender gaps, checking every result strobe against the table or a built-in root predictor

module tb;
  import inr_pkg::*;

  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
  localparam int RANDOM_ITEMS = 1032;
  localparam int WATCHDOG_LIMIT = 20000;
  // covers a worst-case root search at degree 63, plus some slack
  localparam int DRAIN_CYCLES = 2100;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [VALUE_BITS-1:0] root;
    logic                  exact;
  } root_result_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [DEG_BITS-1:0]   degree;
    logic                  known;
    root_result_t          want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [VALUE_BITS-1:0] value_i;
  logic [DEG_BITS-1:0]   degree_i;
  logic                  valid_o;
  logic [VALUE_BITS-1:0] root_o;
  logic                  exact_o;

  root_result_t pending_roots[$];
  int idle_pct;
  int requests_sent;
  int results_checked;
  int exact_hits;
  int fail_count;
  int idle_cycles;

  // rows without known set are checked against the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{31'd1,           6'd1,  1'b1, '{31'd1,           1'b1}},
    '{31'h7FFF_FFFF,   6'd1,  1'b1, '{31'h7FFF_FFFF,   1'b1}},
    '{31'd0,           6'd5,  1'b1, '{31'd0,           1'b1}},
    '{31'd12345,       6'd0,  1'b1, '{31'd12345,       1'b1}},
    '{31'd1,           6'd63, 1'b1, '{31'd1,           1'b1}},
    '{31'h7FFF_FFFF,   6'd63, 1'b1, '{31'd1,           1'b0}},
    '{31'h7FFF_FFFF,   6'd2,  1'b1, '{31'd46340,       1'b0}},
    '{31'h4000_0000,   6'd2,  1'b1, '{31'd32768,       1'b1}},
    '{31'h4000_0000,   6'd30, 1'b1, '{31'd2,           1'b1}},
    '{31'h4000_0000,   6'd31, 1'b1, '{31'd1,           1'b0}},
    '{31'h3FFF_FFFF,   6'd30, 1'b1, '{31'd1,           1'b0}},
    '{31'd1162261467,  6'd19, 1'b1, '{31'd3,           1'b1}},
    '{31'd2,           6'd2,  1'b1, '{31'd1,           1'b0}},
    '{31'd1000000,     6'd3,  1'b1, '{31'd100,         1'b1}},
    '{31'd999999,      6'd3,  1'b1, '{31'd99,          1'b0}},
    '{31'h7FFF_FFFF,   6'd32, 1'b1, '{31'd1,           1'b0}},
    '{31'h5555_5555,   6'd5,  1'b0, '{31'd0,           1'b0}},
    '{31'h2AAA_AAAA,   6'd10, 1'b0, '{31'd0,           1'b0}},
    '{31'h7FFF_FFFF,   6'd21, 1'b0, '{31'd0,           1'b0}},
    '{31'd17,          6'd4,  1'b0, '{31'd0,           1'b0}}
  };

  integer_nth_root_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .value_i  (value_i),
    .degree_i (degree_i),
    .valid_o  (valid_o),
    .root_o   (root_o),
    .exact_o  (exact_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // base^n, or cap + 1 once the running product passes cap
  function automatic longint unsigned pow_capped(longint unsigned base, int unsigned n,
                                                 longint unsigned cap);
    longint unsigned acc;
    acc = 1;
    for (int unsigned k = 0; k < n; k++) begin
      if (base != 0 && acc > cap / base) return cap + 1;
      acc = acc * base;
      if (acc > cap) return cap + 1;
    end
    return acc;
  endfunction

  function automatic root_result_t floor_root(logic [VALUE_BITS-1:0] value,
                                              logic [DEG_BITS-1:0] degree);
    longint unsigned val;
    longint unsigned r;
    longint unsigned cand;
    int unsigned n;
    root_result_t res;
    val = 64'(value);
    n = (degree == 0) ? 1 : int'(degree);
    r = 0;
    for (int b = VALUE_BITS - 1; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand <= val && pow_capped(cand, n, val) <= val) r = cand;
    end
    res.root = r[VALUE_BITS-1:0];
    res.exact = (pow_capped(r, n, val) == val);
    return res;
  endfunction

  // mostly small degrees; values either uniform, of random bit length, or next to a power
  task automatic pick_random_request(output logic [VALUE_BITS-1:0] value,
                                     output logic [DEG_BITS-1:0] degree);
    longint unsigned base;
    longint unsigned v;
    int unsigned n;
    n = ($urandom_range(9) < 7) ? $urandom_range(2, 8) : $urandom_range(1, 63);
    degree = DEG_BITS'(n);
    case ($urandom_range(3))
      0: v = 64'($urandom) & VALUE_MAX;
      1: v = (64'($urandom) & VALUE_MAX) >> $urandom_range(0, VALUE_BITS - 1);
      default: begin
        base = 64'($urandom_range(1, 65535) >> $urandom_range(0, 15));
        if (base == 0) base = 1;
        while (pow_capped(base, n, VALUE_MAX) > VALUE_MAX) base = base >> 1;
        v = pow_capped(base, n, VALUE_MAX) + $urandom_range(2) - 1;
        if (v > VALUE_MAX) v = VALUE_MAX;
      end
    endcase
    if (v == 0) v = 1;
    value = v[VALUE_BITS-1:0];
  endtask

  task automatic send_root_request(logic [VALUE_BITS-1:0] value, logic [DEG_BITS-1:0] degree,
                                   logic known, root_result_t want);
    root_result_t expected;
    expected = known ? want : floor_root(value, degree);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i  <= 1'b1;
    value_i  <= value;
    degree_i <= degree;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_roots.push_back(expected);
    requests_sent++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_pending();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    root_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result: root=%0d exact=%0d", root_o, exact_o);
        fail_count++;
      end else begin
        want = pending_roots.pop_front();
        results_checked++;
        if (exact_o === 1'b1) exact_hits++;
        if (root_o !== want.root) begin
          $error("root mismatch: expected %0d, got %0d", want.root, root_o);
          fail_count++;
        end
        if (exact_o !== want.exact) begin
          $error("exact mismatch: expected %0d, got %0d", want.exact, exact_o);
          fail_count++;
        end
      end
    end
  end

  // counts cycles with neither a request transfer nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** integer_nth_root_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] value;
    logic [DEG_BITS-1:0] degree;
    int phase_idle [3];
    phase_idle = '{0, 78, 22};
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    degree_i = '0;
    idle_pct = 0;
    idle_cycles = 0;
    requests_sent = 0;
    results_checked = 0;
    exact_hits = 0;
    fail_count = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_root_request(directed_rows[i].value, directed_rows[i].degree,
                        directed_rows[i].known, directed_rows[i].want);
    end
    drain_pending();

    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        pick_random_request(value, degree);
        send_root_request(value, degree, 1'b0, '0);
      end
      drain_pending();
    end

    // catch any stray strobe after the last result
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d root requests (directed extremes plus random degrees 1..63)",
             requests_sent);
    $display("checked %0d results, %0d of them exact powers, %0d failures",
             results_checked, exact_hits, fail_count);
    if (fail_count == 0) begin
      $display("** integer_nth_root_core: PASSED **");
    end else begin
      $display("** integer_nth_root_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/inr_pkg.sv
hdl/inr_pow_unit.sv
hdl/integer_nth_root_core.sv
tb/tb.sv
